// ----- design/spt_pkg.sv -----
package spt_pkg;

    // item kind carried in s_tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    // configuration register indexes
    localparam logic REG_SMOOTHING_COEFF = 1'b0;
    localparam logic REG_RISE_OFFSET     = 1'b1;

    // register reset values
    localparam logic [15:0] SMOOTHING_COEFF_RESET = 16'd65470;
    localparam logic [14:0] RISE_OFFSET_RESET     = 15'd1280;

    // field widths
    localparam int SAMPLE_W = 16;
    localparam int COEFF_W  = 16;
    localparam int OFFSET_W = 15;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_SWEEP,
        ST_DRAIN
    } state_t;

    // sequencer outputs
    typedef struct packed {
        logic s_ready;
        logic clear_en;
        logic sweep_issue;
        logic out_load;
    } ctl_t;

endpackage

// ----- design/spt_ram.sv -----
module spt_ram #(
    parameter int DEPTH = 1024,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wa,
    input  logic [WIDTH-1:0]         wd,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] ra,
    output logic [WIDTH-1:0]         rd
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[wa] <= wd;
        end
    end

    // registered read port, holds its data between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rd_data_reg <= mem_reg[ra];
        end
    end

    assign rd = rd_data_reg;

endmodule

// ----- design/spt_blend.sv -----
module spt_blend #(
    parameter int ADDR_W = 10
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    input  logic signed [spt_pkg::SAMPLE_W-1:0] spec,
    input  logic signed [spt_pkg::SAMPLE_W-1:0] peak,
    input  logic [ADDR_W-1:0]                 in_addr,
    input  logic [spt_pkg::COEFF_W-1:0]       coeff,
    input  logic [spt_pkg::OFFSET_W-1:0]      offset,
    output logic                              out_valid,
    output logic [ADDR_W-1:0]                 out_addr,
    output logic signed [spt_pkg::SAMPLE_W-1:0] out_data,
    output logic                              busy
);

    logic [16:0]        coeff_ext;
    logic [16:0]        coeff_inv;
    logic [16:0]        w_spec;
    logic [16:0]        w_peak;
    logic               rise;

    logic               v1_reg;
    logic               rise1_reg;
    logic [ADDR_W-1:0]  addr1_reg;
    logic signed [33:0] prod_s_reg;
    logic signed [33:0] prod_p_reg;

    logic               v2_reg;
    logic               rise2_reg;
    logic [ADDR_W-1:0]  addr2_reg;
    logic signed [33:0] sum_reg;

    logic signed [17:0] avg;
    logic signed [17:0] bumped;
    logic signed [15:0] sat;

    logic               v3_reg;
    logic [ADDR_W-1:0]  addr3_reg;
    logic signed [15:0] res_reg;

    // weight selection: a on the sample when it rises above the peak
    assign coeff_ext = {1'b0, coeff};
    assign coeff_inv = 17'h10000 - coeff_ext;
    assign rise      = spec > peak;
    assign w_spec    = rise ? coeff_ext : coeff_inv;
    assign w_peak    = rise ? coeff_inv : coeff_ext;

    // stage 1: the two weighted products
    always_ff @(posedge aclk) begin
        prod_s_reg <= $signed({1'b0, w_spec}) * spec;
        prod_p_reg <= $signed({1'b0, w_peak}) * peak;
        rise1_reg  <= rise;
        addr1_reg  <= in_addr;
    end

    // stage 2: sum with rounding bias
    always_ff @(posedge aclk) begin
        sum_reg   <= prod_s_reg + prod_p_reg + 34'sd32768;
        rise2_reg <= rise1_reg;
        addr2_reg <= addr1_reg;
    end

    // stage 3: floor to Q8.8, add rise offset, saturate
    assign avg    = sum_reg[33:16];
    assign bumped = avg + (rise2_reg ? $signed({3'b000, offset}) : 18'sd0);

    always_comb begin
        if (bumped > 18'sd32767) begin
            sat = 16'sh7fff;
        end else if (bumped < -18'sd32768) begin
            sat = 16'sh8000;
        end else begin
            sat = bumped[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        res_reg   <= sat;
        addr3_reg <= addr2_reg;
    end

    // stage valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_addr  = addr3_reg;
    assign out_data  = res_reg;
    assign busy      = v1_reg | v2_reg | v3_reg;

endmodule

// ----- design/spectrum_peak_hold_tracker.sv -----
// Spectrum max-hold tracker with exponential decay.
// Input channel (s_*): one item per handshake. s_tuser is the op: a write
// stores s_tdata's sample at (chunk_number-1)*CHUNK_SIZE+position; with
// s_tlast set it then sweeps all bins, blending each stored sample into the
// held peak. A read returns the held peak of read_bin on the m_* channel.
// A write without s_tlast keeps s_tready high. A read holds s_tready low
// until its result from the peak memory is loaded into the free output
// register, where it waits while further items are taken.
// A sweep streams every bin through the read-blend-write pipeline of the
// peak memory at one bin per cycle, with s_tready low until the pipeline drains.
// After reset every entry of both memories is cleared, one per cycle,
// before the first item is taken; configuration writes are taken at any
// time. When m_tready stays low a second read waits inside the block, and
// s_tready drops until the pending result can be loaded.
module spectrum_peak_hold_tracker #(
    parameter int BIN_COUNT  = 1024,
    parameter int CHUNK_SIZE = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    // configuration write port
    input  logic        cfg_wr_en,
    input  logic        cfg_wr_index,
    input  logic [15:0] cfg_wr_data,
    // input channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // chunk_number[2:0], position[10:3], sample[26:11], read_bin[36:27]
    input  logic [39:0] s_tdata,
    input  logic        s_tlast,   // chunk_end
    input  logic        s_tuser,   // op
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // peak_value[15:0], peak_bin[25:16]
    output logic [31:0] m_tdata
);

    localparam int AW         = $clog2(BIN_COUNT);
    localparam int ChunkCount = BIN_COUNT / CHUNK_SIZE;

    spt_pkg::state_t state_reg, state_next;
    spt_pkg::ctl_t   ctl;

    logic [AW-1:0] cnt_reg, cnt_next;
    logic          cnt_last;

    logic [15:0]   coeff_reg;
    logic [14:0]   offset_reg;

    logic [2:0]    f_chunk;
    logic [7:0]    f_pos;
    logic [15:0]   f_sample;
    logic [9:0]    f_bin;

    logic          accept;
    logic          wr_item;
    logic          rd_item;
    logic [15:0]   wa_full;
    logic          wa_ok;

    logic          sweep_rv_reg;
    logic [AW-1:0] sweep_addr_reg;

    logic          spec_we;
    logic [AW-1:0] spec_wa;
    logic [15:0]   spec_wd;
    logic [15:0]   spec_rd;

    logic          peak_we;
    logic [AW-1:0] peak_wa;
    logic [15:0]   peak_wd;
    logic          peak_re;
    logic [AW-1:0] peak_ra;
    logic [15:0]   peak_rd;

    logic          bl_valid;
    logic [AW-1:0] bl_addr;
    logic [15:0]   bl_data;
    logic          bl_busy;

    logic          oor_reg;
    logic [9:0]    bin_reg;
    logic          out_free;
    logic          m_valid_reg;
    logic [15:0]   m_value_reg;
    logic [9:0]    m_bin_reg;

    // input field unpacking
    assign f_chunk  = s_tdata[2:0];
    assign f_pos    = s_tdata[10:3];
    assign f_sample = s_tdata[26:11];
    assign f_bin    = s_tdata[36:27];

    assign accept  = s_tvalid & s_tready;
    assign rd_item = accept & (s_tuser == spt_pkg::OP_READ);

    // write address and range checks
    assign wa_full = (16'(f_chunk) - 16'd1) * 16'(CHUNK_SIZE) + 16'(f_pos);
    assign wa_ok   = (f_chunk != 3'd0) && (int'(f_chunk) <= ChunkCount)
                     && (int'(f_pos) < CHUNK_SIZE) && (int'(wa_full) < BIN_COUNT);
    assign wr_item = accept & (s_tuser == spt_pkg::OP_WRITE) & wa_ok;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coeff_reg  <= spt_pkg::SMOOTHING_COEFF_RESET;
            offset_reg <= spt_pkg::RISE_OFFSET_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                spt_pkg::REG_SMOOTHING_COEFF: coeff_reg  <= cfg_wr_data;
                spt_pkg::REG_RISE_OFFSET:     offset_reg <= cfg_wr_data[14:0];
                default: ;
            endcase
        end
    end

    assign cnt_last = cnt_reg == AW'(BIN_COUNT - 1);
    assign out_free = !m_valid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            spt_pkg::ST_CLEAR: begin
                if (cnt_last) state_next = spt_pkg::ST_IDLE;
            end
            spt_pkg::ST_IDLE: begin
                if (accept) begin
                    if (s_tuser == spt_pkg::OP_READ) begin
                        state_next = spt_pkg::ST_READ;
                    end else if (s_tlast) begin
                        state_next = spt_pkg::ST_SWEEP;
                    end
                end
            end
            spt_pkg::ST_READ: begin
                if (out_free) state_next = spt_pkg::ST_IDLE;
            end
            spt_pkg::ST_SWEEP: begin
                if (cnt_last) state_next = spt_pkg::ST_DRAIN;
            end
            spt_pkg::ST_DRAIN: begin
                if (!sweep_rv_reg && !bl_busy) state_next = spt_pkg::ST_IDLE;
            end
            default: state_next = spt_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctl = '0;
        case (state_reg)
            spt_pkg::ST_CLEAR: ctl.clear_en    = 1'b1;
            spt_pkg::ST_IDLE:  ctl.s_ready     = 1'b1;
            spt_pkg::ST_READ:  ctl.out_load    = out_free;
            spt_pkg::ST_SWEEP: ctl.sweep_issue = 1'b1;
            spt_pkg::ST_DRAIN: ctl             = '0;
            default:           ctl             = '0;
        endcase
    end

    assign s_tready = ctl.s_ready;

    // bin counter shared by clearing pass and sweep
    always_comb begin
        cnt_next = cnt_reg;
        if (ctl.clear_en || ctl.sweep_issue) begin
            cnt_next = cnt_last ? '0 : cnt_reg + AW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= spt_pkg::ST_CLEAR;
            cnt_reg      <= '0;
            sweep_rv_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            sweep_rv_reg <= ctl.sweep_issue;
        end
    end

    always_ff @(posedge aclk) begin
        sweep_addr_reg <= cnt_reg;
    end

    // spectrum memory: clearing and item writes, sweep reads
    assign spec_we = ctl.clear_en | wr_item;
    assign spec_wa = ctl.clear_en ? cnt_reg : wa_full[AW-1:0];
    assign spec_wd = ctl.clear_en ? 16'd0 : f_sample;

    spt_ram #(
        .DEPTH(BIN_COUNT),
        .WIDTH(16)
    ) u_spec_ram (
        .aclk(aclk),
        .we  (spec_we),
        .wa  (spec_wa),
        .wd  (spec_wd),
        .re  (ctl.sweep_issue),
        .ra  (cnt_reg),
        .rd  (spec_rd)
    );

    // peak memory: clearing, sweep read-modify-write, item reads
    assign peak_we = ctl.clear_en | bl_valid;
    assign peak_wa = ctl.clear_en ? cnt_reg : bl_addr;
    assign peak_wd = ctl.clear_en ? 16'd0 : bl_data;
    assign peak_re = ctl.sweep_issue | rd_item;
    assign peak_ra = ctl.sweep_issue ? cnt_reg : AW'(f_bin);

    spt_ram #(
        .DEPTH(BIN_COUNT),
        .WIDTH(16)
    ) u_peak_ram (
        .aclk(aclk),
        .we  (peak_we),
        .wa  (peak_wa),
        .wd  (peak_wd),
        .re  (peak_re),
        .ra  (peak_ra),
        .rd  (peak_rd)
    );

    // peak update pipeline
    spt_blend #(
        .ADDR_W(AW)
    ) u_blend (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (sweep_rv_reg),
        .spec     (spec_rd),
        .peak     (peak_rd),
        .in_addr  (sweep_addr_reg),
        .coeff    (coeff_reg),
        .offset   (offset_reg),
        .out_valid(bl_valid),
        .out_addr (bl_addr),
        .out_data (bl_data),
        .busy     (bl_busy)
    );

    // read item bookkeeping
    always_ff @(posedge aclk) begin
        if (rd_item) begin
            bin_reg <= f_bin;
            oor_reg <= !(int'(f_bin) < BIN_COUNT);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (ctl.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_load) begin
            m_value_reg <= oor_reg ? 16'd0 : peak_rd;
            m_bin_reg   <= bin_reg;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_bin_reg, m_value_reg};

endmodule

// ----- dv/tb_spectrum_peak_hold_tracker.sv -----
`timescale 1ns / 100ps

module tb_spectrum_peak_hold_tracker;

    localparam int BIN_COUNT    = 1024;
    localparam int CHUNK_SIZE   = 256;
    localparam int CHUNK_COUNT  = BIN_COUNT / CHUNK_SIZE;
    localparam int SWEEP_SETTLE = BIN_COUNT + 32;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_COUNT  = 6;
    localparam int PHASE_ITEMS  = 247;

    // one input item, unpacked
    typedef struct {
        logic               op;
        logic [2:0]         chunk;
        logic [7:0]         pos;
        logic signed [15:0] sample;
        logic               chunk_end;
        logic [9:0]         read_bin;
    } spec_item_t;

    // one expected read result
    typedef struct {
        logic signed [15:0] value;
        logic [9:0]         bin;
    } peak_result_t;

    // spectrum and held-peak mirror with queue of expected reads
    class peak_hold_board;
        logic signed [15:0] spectrum_bins [BIN_COUNT];
        logic signed [15:0] held_peaks [BIN_COUNT];
        logic [15:0]        coeff;
        logic [14:0]        rise_amount;
        peak_result_t       pending_peaks [$];
        int                 mismatch_count;
        int                 items_noted;
        int                 peaks_checked;
        int                 sweep_count;

        function new();
            foreach (spectrum_bins[i]) begin
                spectrum_bins[i] = '0;
                held_peaks[i]    = '0;
            end
            coeff          = spt_pkg::SMOOTHING_COEFF_RESET;
            rise_amount    = spt_pkg::RISE_OFFSET_RESET;
            mismatch_count = 0;
            items_noted    = 0;
            peaks_checked  = 0;
            sweep_count    = 0;
        endfunction

        function void set_reg(logic idx, logic [15:0] value);
            if (idx == spt_pkg::REG_SMOOTHING_COEFF) begin
                coeff = value;
            end else begin
                rise_amount = value[14:0];
            end
        endfunction

        // weighted blend rounded half up to Q8.8, then offset and saturate
        function logic signed [15:0] mix_q88(longint w1, longint x, longint w2,
                                            longint y, longint add);
            longint acc;
            acc = w1 * x + w2 * y + 32768;
            acc = (acc >>> 16) + add;
            if (acc > 32767) acc = 32767;
            if (acc < -32768) acc = -32768;
            return acc[15:0];
        endfunction

        // fold every stored sample into its held peak
        function void decay_sweep();
            longint a;
            longint na;
            longint s;
            longint p;
            a  = longint'(coeff);
            na = 65536 - a;
            for (int i = 0; i < BIN_COUNT; i++) begin
                s = longint'(spectrum_bins[i]);
                p = longint'(held_peaks[i]);
                if (s > p) begin
                    held_peaks[i] = mix_q88(a, s, na, p, longint'(rise_amount));
                end else begin
                    held_peaks[i] = mix_q88(na, s, a, p, 0);
                end
            end
            sweep_count++;
        endfunction

        function void note_item(spec_item_t it);
            peak_result_t want;
            int           addr;
            items_noted++;
            if (it.op == spt_pkg::OP_WRITE) begin
                // out-of-range chunk drops the sample but still sweeps
                if (it.chunk >= 1 && it.chunk <= CHUNK_COUNT) begin
                    addr = (int'(it.chunk) - 1) * CHUNK_SIZE + int'(it.pos);
                    spectrum_bins[addr] = it.sample;
                end
                if (it.chunk_end) decay_sweep();
            end else begin
                want.value = held_peaks[it.read_bin];
                want.bin   = it.read_bin;
                pending_peaks.push_back(want);
            end
        endfunction

        function void check_peak(logic [31:0] data);
            peak_result_t want;
            if (pending_peaks.size() == 0) begin
                $error("result with no read waiting: peak_value %0d peak_bin %0d",
                       $signed(data[15:0]), data[25:16]);
                mismatch_count++;
                return;
            end
            want = pending_peaks.pop_front();
            peaks_checked++;
            if (data[15:0] !== want.value) begin
                $error("peak_value mismatch: expected %0d, actual %0d",
                       want.value, $signed(data[15:0]));
                mismatch_count++;
            end
            if (data[25:16] !== want.bin) begin
                $error("peak_bin mismatch: expected %0d, actual %0d",
                       want.bin, data[25:16]);
                mismatch_count++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_index = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tlast = 1'b0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    peak_hold_board sb;
    int          tx_gap_pct = 0;
    int          rx_stall_pct = 0;
    int          cycle_count = 0;
    logic [9:0]  last_bin = '0;

    // register plan per phase, extremes included; last phase is random
    logic [15:0] coeff_plan [PHASE_COUNT] = '{16'd65470, 16'd0, 16'd65535,
                                              16'd32768, 16'd1, 16'd0};
    logic [14:0] rise_plan  [PHASE_COUNT] = '{15'd1280, 15'd0, 15'd32767,
                                              15'd256, 15'd1, 15'd0};

    spectrum_peak_hold_tracker #(
        .BIN_COUNT (BIN_COUNT),
        .CHUNK_SIZE(CHUNK_SIZE)
    ) uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_index(cfg_wr_index),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #6;
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end

    // check results, then note accepted items
    always @(posedge aclk) begin
        spec_item_t seen;
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_peak(m_tdata);
            if (s_tvalid && s_tready) begin
                seen.op        = s_tuser;
                seen.chunk     = s_tdata[2:0];
                seen.pos       = s_tdata[10:3];
                seen.sample    = s_tdata[26:11];
                seen.chunk_end = s_tlast;
                seen.read_bin  = s_tdata[36:27];
                sb.note_item(seen);
            end
        end
    end

    function automatic spec_item_t make_item(logic op, logic [2:0] chunk, logic [7:0] pos,
                                             logic [15:0] sample, logic chunk_end,
                                             logic [9:0] read_bin);
        spec_item_t it;
        it.op        = op;
        it.chunk     = chunk;
        it.pos       = pos;
        it.sample    = sample;
        it.chunk_end = chunk_end;
        it.read_bin  = read_bin;
        return it;
    endfunction

    // mostly well-formed writes and reads, some bad chunks and stray flags
    function automatic spec_item_t random_item();
        spec_item_t it;
        int         kind;
        it.op    = ($urandom_range(0, 99) < 40) ? spt_pkg::OP_READ : spt_pkg::OP_WRITE;
        it.chunk = ($urandom_range(0, 99) < 92) ? 3'($urandom_range(1, CHUNK_COUNT))
                                                : 3'($urandom_range(0, 7));
        it.pos   = 8'($urandom_range(0, 255));
        kind     = $urandom_range(0, 9);
        if (kind == 0) begin
            it.sample = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
        end else if (kind <= 3) begin
            it.sample = 16'($urandom_range(0, 65535));
        end else begin
            it.sample = 16'($urandom_range(0, 5120) - 2560);
        end
        if (it.op == spt_pkg::OP_WRITE) begin
            it.chunk_end = ($urandom_range(0, 39) == 0);
            if (it.chunk >= 1 && it.chunk <= CHUNK_COUNT)
                last_bin = 10'((int'(it.chunk) - 1) * CHUNK_SIZE + int'(it.pos));
        end else begin
            it.chunk_end = ($urandom_range(0, 9) == 0);
        end
        it.read_bin = ($urandom_range(0, 99) < 30) ? last_bin
                                                   : 10'($urandom_range(0, 1023));
        return it;
    endfunction

    // offer one item, with random sender gaps, until taken
    task automatic push_item(spec_item_t it);
        while ($urandom_range(0, 99) < tx_gap_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= it.op;
        s_tlast  <= it.chunk_end;
        s_tdata  <= {3'b000, it.read_bin, it.sample, it.pos, it.chunk};
        do @(posedge aclk); while (!s_tready);
    endtask

    // sender holds off until every read has returned
    task automatic wait_peaks_done();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (sb.pending_peaks.size() != 0);
    endtask

    // idle point: results back, any sweep finished
    task automatic drain_block();
        wait_peaks_done();
        repeat (SWEEP_SETTLE) @(posedge aclk);
    endtask

    task automatic set_regs(logic [15:0] coeff, logic [14:0] rise);
        cfg_wr_en    <= 1'b1;
        cfg_wr_index <= spt_pkg::REG_SMOOTHING_COEFF;
        cfg_wr_data  <= coeff;
        @(posedge aclk);
        cfg_wr_index <= spt_pkg::REG_RISE_OFFSET;
        cfg_wr_data  <= {1'b0, rise};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.set_reg(spt_pkg::REG_SMOOTHING_COEFF, coeff);
        sb.set_reg(spt_pkg::REG_RISE_OFFSET, {1'b0, rise});
    endtask

    initial begin
        sb = new();
        coeff_plan[PHASE_COUNT-1] = 16'($urandom_range(0, 65535));
        rise_plan[PHASE_COUNT-1]  = 15'($urandom_range(0, 32767));
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed part under reset register values
        tx_gap_pct   = 6;
        rx_stall_pct = 57;
        set_regs(coeff_plan[0], rise_plan[0]);
        push_item(make_item(spt_pkg::OP_READ, 3'd1, 8'd0, 16'h0000, 1'b0, 10'd0));
        // chunk end on a read is ignored
        push_item(make_item(spt_pkg::OP_READ, 3'd7, 8'd255, 16'hFFFF, 1'b1, 10'd1023));
        push_item(make_item(spt_pkg::OP_WRITE, 3'd1, 8'd0, 16'h7FFF, 1'b0, 10'h3FF));
        push_item(make_item(spt_pkg::OP_WRITE, 3'd4, 8'd255, 16'h8000, 1'b0, 10'h000));
        push_item(make_item(spt_pkg::OP_WRITE, 3'd2, 8'd17, 16'h0001, 1'b0, 10'h155));
        push_item(make_item(spt_pkg::OP_WRITE, 3'd3, 8'd128, 16'h1234, 1'b0, 10'h2AA));
        // bad chunks drop the sample, the last one still sweeps
        push_item(make_item(spt_pkg::OP_WRITE, 3'd0, 8'd5, 16'h0BAD, 1'b0, 10'd5));
        push_item(make_item(spt_pkg::OP_WRITE, 3'd5, 8'd3, 16'h4000, 1'b0, 10'd3));
        push_item(make_item(spt_pkg::OP_WRITE, 3'd6, 8'd0, 16'hC000, 1'b0, 10'd0));
        push_item(make_item(spt_pkg::OP_WRITE, 3'd7, 8'd255, 16'hFFFF, 1'b1, 10'd1023));
        push_item(make_item(spt_pkg::OP_READ, 3'd0, 8'd0, 16'h0000, 1'b0, 10'd0));
        push_item(make_item(spt_pkg::OP_READ, 3'd0, 8'd0, 16'h0000, 1'b0, 10'd1023));
        push_item(make_item(spt_pkg::OP_READ, 3'd0, 8'd0, 16'h0000, 1'b0, 10'd273));
        push_item(make_item(spt_pkg::OP_READ, 3'd0, 8'd0, 16'h0000, 1'b0, 10'd640));
        push_item(make_item(spt_pkg::OP_READ, 3'd0, 8'd0, 16'h0000, 1'b0, 10'd5));
        // falling sample takes the decay path
        push_item(make_item(spt_pkg::OP_WRITE, 3'd1, 8'd0, 16'h8000, 1'b1, 10'd0));
        push_item(make_item(spt_pkg::OP_READ, 3'd0, 8'd0, 16'h0000, 1'b0, 10'd0));
        push_item(make_item(spt_pkg::OP_READ, 3'd0, 8'd0, 16'h0000, 1'b0, 10'd1023));
        // full-scale rise toward saturation
        push_item(make_item(spt_pkg::OP_WRITE, 3'd2, 8'd17, 16'h7FFF, 1'b1, 10'd273));
        push_item(make_item(spt_pkg::OP_READ, 3'd2, 8'd17, 16'h7FFF, 1'b0, 10'd273));
        wait_peaks_done();

        // random phases, each with its own registers and idling
        for (int p = 0; p < PHASE_COUNT; p++) begin
            if (p > 0) begin
                drain_block();
                set_regs(coeff_plan[p], rise_plan[p]);
            end
            case (p % 3)
                0: begin
                    tx_gap_pct   = 6;
                    rx_stall_pct = 57;
                end
                1: begin
                    tx_gap_pct   = 57;
                    rx_stall_pct = 6;
                end
                default: begin
                    tx_gap_pct   = 0;
                    rx_stall_pct = 0;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 1 && n == PHASE_ITEMS / 2) wait_peaks_done();
                push_item(random_item());
            end
        end
        drain_block();

        if (sb.pending_peaks.size() != 0) begin
            $error("%0d reads never returned", sb.pending_peaks.size());
            sb.mismatch_count++;
        end
        $display("run covered %0d items over %0d register settings with %0d sweeps",
                 sb.items_noted, PHASE_COUNT, sb.sweep_count);
        $display("%0d held peaks read back and compared", sb.peaks_checked);
        if (sb.mismatch_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
